@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the clock, off during reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

@@ rtl/core/mtsf_pkg.sv @@
// ----------------------------------------------------------------------------
// mtsf_pkg
// Types and constants for the multiplexed tube scanner with fade.
// ----------------------------------------------------------------------------
package mtsf_pkg;

  localparam int FRAME_W = 16;
  localparam int ON_W    = 8;
  localparam int FADE_W  = 20;
  localparam int DIGIT_W = 4;
  localparam int LOAD_DIGITS = 4;

  localparam logic [FRAME_W-1:0] FRAME_RESET  = 16'd320;
  localparam logic [ON_W-1:0]    BRIGHT_RESET = 8'd50;
  localparam logic [ON_W-1:0]    DIM_RESET    = 8'd4;
  localparam logic [FADE_W-1:0]  FADE_RESET   = 20'd10000;
  localparam int SI_RESET_INT = 10000 / (50 - 4);
  localparam logic [FADE_W-1:0]  SI_RESET     = FADE_W'(SI_RESET_INT);

  localparam int DIV_W     = FADE_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_FRAME_TICKS = 2'd0;
  localparam logic [1:0] REG_BRIGHT_ON   = 2'd1;
  localparam logic [1:0] REG_DIM_ON      = 2'd2;
  localparam logic [1:0] REG_FADE_TICKS  = 2'd3;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_LOAD = 2'd1;
  localparam logic [1:0] REQ_DIM  = 2'd2;

  typedef enum logic [1:0] {
    STG_FULL = 2'd0,
    STG_DOWN = 2'd1,
    STG_DIM  = 2'd2,
    STG_UP   = 2'd3
  } stage_t;

  typedef enum logic [1:0] {
    DS_IDLE  = 2'd0,
    DS_STEP  = 2'd1,
    DS_PHASE = 2'd2
  } div_state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               dim_on;
    logic [DIGIT_W-1:0] digit_a;
    logic [DIGIT_W-1:0] digit_b;
    logic [DIGIT_W-1:0] digit_c;
    logic [DIGIT_W-1:0] digit_d;
  } mtsf_in_t;

  typedef struct packed {
    logic               slot_start;
    logic               tube_lit;
    logic [1:0]         tube_index;
    logic [DIGIT_W-1:0] digit_out;
    logic [ON_W-1:0]    on_time_now;
    logic [1:0]         fade_stage;
  } mtsf_out_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

@@ rtl/core/mtsf_div.sv @@
// ----------------------------------------------------------------------------
// mtsf_div
// Restoring divider, one quotient bit per cycle, done pulse after the last quotient bit.
// ----------------------------------------------------------------------------
module mtsf_div
  import mtsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       diff;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dvs_nxt = req.divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[DIV_W]) begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy      = run_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

@@ rtl/core/multiplexed_tube_scanner_with_fade.sv @@
// ----------------------------------------------------------------------------
// Multiplexed tube scanner with fade
// Takes one beat per clock while in_stall is low: a tick, a digit load or a dim
// request. Every tick yields one result beat, registered, with a skid stage so a
// new beat is taken while a result waits. The fade step interval and the current
// fade phase come from a one-bit-per-cycle divider; after each register write the
// input stalls until the interval and (for nonzero range and interval) phase
// divisions end. After reset the reset-value interval is preloaded, no stall occurs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multiplexed_tube_scanner_with_fade
  import mtsf_pkg::*;
#(
  parameter int TUBE_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mtsf_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mtsf_out_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [FRAME_W-1:0] frame_ticks_r;
  logic [ON_W-1:0]    bright_r;
  logic [ON_W-1:0]    dim_r;
  logic [FADE_W-1:0]  fade_ticks_r;

  logic [FRAME_W-1:0] timer_r, timer_nxt;
  logic [ON_W-1:0]    slot_r, slot_nxt;
  stage_t             stage_r, stage_nxt;
  logic [FADE_W-1:0]  fc_r, fc_nxt;
  logic [FADE_W-1:0]  phase_r, phase_nxt;
  logic [ON_W-1:0]    quot_r, quot_nxt;
  logic [FADE_W-1:0]  si_r, si_nxt;
  logic [DIGIT_W-1:0] digits_r [TUBE_COUNT];
  logic [DIGIT_W-1:0] digits_nxt [TUBE_COUNT];

  div_state_t div_state_r, div_state_nxt;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  logic       wr_d_r;
  logic       si_ld, ph_ld, ph_clr;

  logic       out_valid_r, out_valid_nxt;
  mtsf_out_t  out_data_r, out_data_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  mtsf_out_t  skid_data_r, skid_data_nxt;

  logic               cfg_wr;
  logic               in_acc;
  logic [ON_W-1:0]    range;
  logic [DIGIT_W-1:0] ld [LOAD_DIGITS];

  logic               fading;
  logic [FADE_W-1:0]  fc_inc, ph_a, ph_f, fc_f;
  logic [ON_W-1:0]    q_a, q_f, slot_a, slot_f;
  logic               step_hit;
  stage_t             stage_f;

  logic [FRAME_W-1:0] ft1;
  logic               hit, lit;
  logic [1:0]         hit_idx;
  logic [DIGIT_W-1:0] hit_dig;
  logic [FRAME_W-1:0] timer_f;

  mtsf_out_t res;
  logic      res_vld;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_TICKS: prdata = DATA_W'(frame_ticks_r);
      REG_BRIGHT_ON:   prdata = DATA_W'(bright_r);
      REG_DIM_ON:      prdata = DATA_W'(dim_r);
      REG_FADE_TICKS:  prdata = DATA_W'(fade_ticks_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_ticks_r <= FRAME_RESET;
      bright_r      <= BRIGHT_RESET;
      dim_r         <= DIM_RESET;
      fade_ticks_r  <= FADE_RESET;
      wr_d_r        <= 1'b0;
    end else begin
      wr_d_r <= cfg_wr;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_FRAME_TICKS: frame_ticks_r <= pwdata[FRAME_W-1:0];
          REG_BRIGHT_ON:   bright_r      <= pwdata[ON_W-1:0];
          REG_DIM_ON:      dim_r         <= pwdata[ON_W-1:0];
          REG_FADE_TICKS:  fade_ticks_r  <= pwdata[FADE_W-1:0];
          default:         ;
        endcase
      end
    end
  end

  assign range = (bright_r > dim_r) ? (bright_r - dim_r) : '0;

  // Step interval and fade phase recompute after a register write.
  mtsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    div_state_nxt    = div_state_r;
    div_req.start    = 1'b0;
    div_req.dividend = fade_ticks_r;
    div_req.divisor  = DIV_W'(range);
    si_ld            = 1'b0;
    ph_ld            = 1'b0;
    ph_clr           = 1'b0;
    if (wr_d_r) begin
      div_req.start = 1'b1;
      div_state_nxt = DS_STEP;
    end else begin
      case (div_state_r)
        DS_IDLE: ;
        DS_STEP: begin
          if (div_rsp.done) begin
            si_ld = 1'b1;
            if (range != '0 && div_rsp.quotient != '0) begin
              div_req.start    = 1'b1;
              div_req.dividend = fc_r;
              div_req.divisor  = div_rsp.quotient;
              div_state_nxt    = DS_PHASE;
            end else begin
              ph_clr        = 1'b1;
              div_state_nxt = DS_IDLE;
            end
          end
        end
        DS_PHASE: begin
          if (div_rsp.done) begin
            ph_ld         = 1'b1;
            div_state_nxt = DS_IDLE;
          end
        end
        default: div_state_nxt = DS_IDLE;
      endcase
    end
  end

  assign in_stall = skid_valid_r || wr_d_r || cfg_wr || (div_state_r != DS_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Fade advance for a tick.
  always_comb begin
    fading = (stage_r == STG_DOWN) || (stage_r == STG_UP);
    fc_inc = fc_r + 1'b1;
    if (fc_inc == '0) begin
      ph_a = '0;
      q_a  = '0;
    end else if (phase_r + 1'b1 == si_r) begin
      ph_a = '0;
      q_a  = (quot_r == '1) ? quot_r : quot_r + 1'b1;
    end else begin
      ph_a = phase_r + 1'b1;
      q_a  = quot_r;
    end
    step_hit = (si_r != '0) && (ph_a == '0) && (q_a < range);
    slot_a   = slot_r;
    if (step_hit) begin
      slot_a = (stage_r == STG_DOWN) ? slot_r - 1'b1 : slot_r + 1'b1;
    end
    fc_f    = fc_inc;
    ph_f    = ph_a;
    q_f     = q_a;
    slot_f  = slot_a;
    stage_f = stage_r;
    if (fc_inc == fade_ticks_r) begin
      fc_f    = '0;
      ph_f    = '0;
      q_f     = '0;
      slot_f  = (stage_r == STG_DOWN) ? dim_r : bright_r;
      stage_f = (stage_r == STG_DOWN) ? STG_DIM : STG_FULL;
    end
    if (!fading) begin
      fc_f    = fc_r;
      ph_f    = phase_r;
      q_f     = quot_r;
      slot_f  = slot_r;
      stage_f = stage_r;
    end
  end

  // Slot boundary search; the lowest slot number wins.
  always_comb begin
    ft1     = timer_r + 1'b1;
    hit     = 1'b0;
    lit     = 1'b0;
    hit_idx = '0;
    hit_dig = '0;
    if ({1'b0, ft1} == 17'(TUBE_COUNT) * {9'd0, slot_f} + 17'd1) begin
      hit = 1'b1;
    end
    for (int i = TUBE_COUNT - 1; i >= 0; i--) begin
      if ({1'b0, ft1} == 17'(i) * {9'd0, slot_f} + 17'd1) begin
        hit     = 1'b1;
        lit     = 1'b1;
        hit_idx = 2'(i);
        hit_dig = digits_r[i];
      end
    end
    timer_f = ft1;
    if (!hit && ({1'b0, ft1} >= {1'b0, frame_ticks_r} + 17'd1)) begin
      timer_f = '0;
    end
  end

  assign ld[0] = in_data.digit_a;
  assign ld[1] = in_data.digit_b;
  assign ld[2] = in_data.digit_c;
  assign ld[3] = in_data.digit_d;

  // Item handling and state update.
  always_comb begin
    timer_nxt  = timer_r;
    slot_nxt   = slot_r;
    stage_nxt  = stage_r;
    fc_nxt     = fc_r;
    phase_nxt  = phase_r;
    quot_nxt   = quot_r;
    si_nxt     = si_r;
    digits_nxt = digits_r;
    res        = '0;
    res_vld    = 1'b0;
    if (in_acc) begin
      case (in_data.req_type)
        REQ_TICK: begin
          fc_nxt          = fc_f;
          phase_nxt       = ph_f;
          quot_nxt        = q_f;
          slot_nxt        = slot_f;
          stage_nxt       = stage_f;
          timer_nxt       = timer_f;
          res_vld         = 1'b1;
          res.slot_start  = hit;
          res.tube_lit    = lit;
          res.tube_index  = hit_idx;
          res.digit_out   = hit_dig;
          res.on_time_now = slot_f;
          res.fade_stage  = stage_f;
        end
        REQ_LOAD: begin
          for (int i = 0; i < TUBE_COUNT; i++) begin
            if (i < LOAD_DIGITS) begin
              digits_nxt[i] = ld[2'(i)];
            end
          end
        end
        REQ_DIM: begin
          if (in_data.dim_on) begin
            if (stage_r != STG_DIM) begin
              stage_nxt = STG_DOWN;
            end
          end else begin
            if (stage_r != STG_FULL) begin
              stage_nxt = STG_UP;
            end
          end
        end
        default: ;
      endcase
    end
    if (si_ld) begin
      si_nxt = (range != '0) ? div_rsp.quotient : '0;
    end
    if (ph_clr) begin
      phase_nxt = '0;
      quot_nxt  = '0;
    end
    if (ph_ld) begin
      phase_nxt = div_rsp.remainder;
      quot_nxt  = (div_rsp.quotient > DIV_W'(8'hFF)) ? 8'hFF : div_rsp.quotient[ON_W-1:0];
    end
  end

  // Output register with skid stage.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r) begin
      out_valid_nxt = res_vld;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_vld;
        out_data_nxt  = res;
      end
    end else if (res_vld) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r      <= '0;
      slot_r       <= BRIGHT_RESET;
      stage_r      <= STG_FULL;
      fc_r         <= '0;
      phase_r      <= '0;
      quot_r       <= '0;
      si_r         <= SI_RESET;
      div_state_r  <= DS_IDLE;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      for (int i = 0; i < TUBE_COUNT; i++) begin
        digits_r[i] <= '0;
      end
    end else begin
      timer_r      <= timer_nxt;
      slot_r       <= slot_nxt;
      stage_r      <= stage_nxt;
      fc_r         <= fc_nxt;
      phase_r      <= phase_nxt;
      quot_r       <= quot_nxt;
      si_r         <= si_nxt;
      div_state_r  <= div_state_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      digits_r     <= digits_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_PROP(a_skid_behind_out, clk, rst_n, skid_valid_r |-> out_valid_r, "skid full while output empty")
  `ASSERT_PROP(a_tick_gives_beat, clk, rst_n, (in_acc && in_data.req_type == REQ_TICK) |=> out_valid_r, "tick produced no result")
  `ASSERT_PROP(a_counter_idle, clk, rst_n, (stage_r == STG_FULL || stage_r == STG_DIM) |-> (fc_r == '0), "fade counter running outside a fade")
  `ASSERT_PROP(a_phase_range, clk, rst_n, (div_state_r == DS_IDLE && !wr_d_r && si_r != '0) |-> (phase_r < si_r), "fade phase beyond step interval")

endmodule

@@ tb/sv/multiplexed_tube_scanner_with_fade_test.sv @@
// ----------------------------------------------------------------------------
// Multiplexed tube scanner with fade: testbench
// A queue-fed driver sends ticks, digit loads, dim requests and spare-type
// beats. Both sides insert random gaps. A scan and fade predictor runs on every
// accepted beat and queues the result that each tick should produce. A monitor
// checks every result beat field by field against the oldest queued result.
// The run walks through several register settings, including the largest
// frame, fade and bright-on values.
// ----------------------------------------------------------------------------
module multiplexed_tube_scanner_with_fade_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mtsf_pkg::*;

  localparam int TUBES = 4;
  localparam int RUN_LIMIT = 200_000;
  localparam int REG_GAP = 50;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [31:0] MASK_FRAME = 32'h0000_FFFF;
  localparam logic [31:0] MASK_ON = 32'h0000_00FF;
  localparam logic [31:0] MASK_FADE = 32'h000F_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mtsf_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mtsf_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  multiplexed_tube_scanner_with_fade #(
    .TUBE_COUNT(TUBES)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state.
  logic [FRAME_W-1:0] reg_frame;
  logic [ON_W-1:0] reg_bright;
  logic [ON_W-1:0] reg_dim;
  logic [FADE_W-1:0] reg_fade;
  logic [FRAME_W-1:0] scan_timer;
  logic [ON_W-1:0] slot_len;
  stage_t fade_phase;
  logic [FADE_W-1:0] fade_cnt;
  logic [FADE_W-1:0] step_len;
  logic [DIGIT_W-1:0] tube_digit[TUBES];

  mtsf_in_t pending_beats[$];
  mtsf_out_t expected_beats[$];
  int err_count = 0;
  int cycle_count = 0;
  bit in_took = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  bit in_idle_en = 1'b1;
  bit out_idle_en = 1'b1;

  function automatic int fade_span();
    return (reg_bright > reg_dim) ? int'(reg_bright) - int'(reg_dim) : 0;
  endfunction

  function automatic void derive_step_len();
    int span;
    span = fade_span();
    step_len = (span != 0) ? FADE_W'(int'(reg_fade) / span) : '0;
  endfunction

  function automatic void reset_scanner_model();
    reg_frame = FRAME_RESET;
    reg_bright = BRIGHT_RESET;
    reg_dim = DIM_RESET;
    reg_fade = FADE_RESET;
    scan_timer = '0;
    slot_len = BRIGHT_RESET;
    fade_phase = STG_FULL;
    fade_cnt = '0;
    foreach (tube_digit[k]) tube_digit[k] = '0;
    derive_step_len();
  endfunction

  function automatic void predict_scan(mtsf_in_t it);
    int span;
    int slot;
    bit started;
    mtsf_out_t res;
    res = '0;
    case (it.req_type)
      REQ_LOAD: begin
        tube_digit[0] = it.digit_a;
        tube_digit[1] = it.digit_b;
        tube_digit[2] = it.digit_c;
        tube_digit[3] = it.digit_d;
      end
      REQ_DIM: begin
        if (!(it.dim_on && fade_phase == STG_DIM) && !(!it.dim_on && fade_phase == STG_FULL))
          fade_phase = it.dim_on ? STG_DOWN : STG_UP;
      end
      REQ_TICK: begin
        if (fade_phase == STG_DOWN || fade_phase == STG_UP) begin
          span = fade_span();
          fade_cnt = fade_cnt + FADE_W'(1);
          if (step_len != 0 && fade_cnt % step_len == 0 && int'(fade_cnt / step_len) < span)
            slot_len = (fade_phase == STG_DOWN) ? slot_len - 8'd1 : slot_len + 8'd1;
          if (fade_cnt == reg_fade) begin
            fade_cnt = '0;
            if (fade_phase == STG_DOWN) begin
              slot_len = reg_dim;
              fade_phase = STG_DIM;
            end else begin
              slot_len = reg_bright;
              fade_phase = STG_FULL;
            end
          end
        end
        scan_timer = scan_timer + FRAME_W'(1);
        started = 1'b0;
        for (slot = 0; slot <= TUBES && !started; slot++) begin
          if (int'(scan_timer) == slot * int'(slot_len) + 1) begin
            started = 1'b1;
            res.slot_start = 1'b1;
            if (slot < TUBES) begin
              res.tube_lit = 1'b1;
              res.tube_index = 2'(slot);
              res.digit_out = tube_digit[slot];
            end
          end
        end
        if (!started && int'(scan_timer) >= int'(reg_frame) + 1) scan_timer = '0;
        res.on_time_now = slot_len;
        res.fade_stage = fade_phase;
        expected_beats.push_back(res);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic mtsf_in_t random_beat(logic [1:0] req);
    mtsf_in_t it;
    it = $bits(mtsf_in_t)'($urandom());
    it.req_type = req;
    return it;
  endfunction

  function automatic mtsf_in_t mixed_beat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) return random_beat(REQ_TICK);
    if (r < 80) return random_beat(REQ_LOAD);
    if (r < 95) return random_beat(REQ_DIM);
    return random_beat(REQ_SPARE);
  endfunction

  function automatic mtsf_in_t make_beat(logic [1:0] req, logic dim, logic [3:0] a,
                                         logic [3:0] b, logic [3:0] c, logic [3:0] d);
    mtsf_in_t it;
    it = '{req_type: req, dim_on: dim, digit_a: a, digit_b: b, digit_c: c, digit_d: d};
    return it;
  endfunction

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Input driver.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      in_took = 1'b0;
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_beats.size() > 0) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
        if (in_idle_en) in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side stalls.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap--;
    end else begin
      out_stall <= 1'b0;
      if (out_idle_en) out_gap = pick_gap();
    end
  end

  // Monitor and predictor hookup.
  always @(posedge clk) begin
    mtsf_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no expected result: %h", out_data);
          err_count++;
        end else begin
          want = expected_beats.pop_front();
          report_field("slot_start", want.slot_start, out_data.slot_start);
          report_field("tube_lit", want.tube_lit, out_data.tube_lit);
          report_field("tube_index", want.tube_index, out_data.tube_index);
          report_field("digit_out", want.digit_out, out_data.digit_out);
          report_field("on_time_now", want.on_time_now, out_data.on_time_now);
          report_field("fade_stage", want.fade_stage, out_data.fade_stage);
        end
      end
      if (in_valid && !in_stall) begin
        predict_scan(in_data);
        in_took = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_valid || expected_beats.size() > 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value, logic [31:0] mask);
    logic [31:0] word;
    word = (value & mask) | ($urandom() & ~mask);
    repeat (REG_GAP) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata != (value & mask)) begin
      $error("prdata of register %0d: expected %0d, got %0d", idx, value & mask, prdata);
      err_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_FRAME_TICKS: reg_frame = value[FRAME_W-1:0];
      REG_BRIGHT_ON: reg_bright = value[ON_W-1:0];
      REG_DIM_ON: reg_dim = value[ON_W-1:0];
      REG_FADE_TICKS: reg_fade = value[FADE_W-1:0];
      default: ;
    endcase
    derive_step_len();
  endtask

  // Lets a running fade land so that a smaller fade length never strands it.
  task automatic settle_fade();
    wait_idle();
    if (fade_phase == STG_DOWN || fade_phase == STG_UP) begin
      repeat (int'(reg_fade) - int'(fade_cnt)) pending_beats.push_back(random_beat(REQ_TICK));
      wait_idle();
    end
  endtask

  task automatic set_config(int frame, int bright, int dim, int fade);
    settle_fade();
    cfg_write(REG_FRAME_TICKS, 32'(frame), MASK_FRAME);
    cfg_write(REG_BRIGHT_ON, 32'(bright), MASK_ON);
    cfg_write(REG_DIM_ON, 32'(dim), MASK_ON);
    cfg_write(REG_FADE_TICKS, 32'(fade), MASK_FADE);
  endtask

  task automatic run_phase(int frame, int bright, int dim, int fade, int count, bit idle);
    set_config(frame, bright, dim, fade);
    in_idle_en = idle;
    out_idle_en = idle;
    repeat (count / 2) pending_beats.push_back(mixed_beat());
    wait_idle();
    repeat (count - count / 2) pending_beats.push_back(mixed_beat());
    wait_idle();
  endtask

  initial begin
    int bright;
    int dim;
    reset_scanner_model();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    pending_beats.push_back(make_beat(REQ_LOAD, 1'b0, 4'hF, 4'h0, 4'hA, 4'h5));
    repeat (3) pending_beats.push_back(random_beat(REQ_TICK));
    pending_beats.push_back(make_beat(REQ_DIM, 1'b0, 4'h0, 4'h0, 4'h0, 4'h0));
    pending_beats.push_back(make_beat(REQ_SPARE, 1'b1, 4'hF, 4'hF, 4'hF, 4'hF));
    pending_beats.push_back(make_beat(REQ_DIM, 1'b1, 4'hF, 4'hF, 4'hF, 4'hF));
    repeat (5) pending_beats.push_back(random_beat(REQ_TICK));
    pending_beats.push_back(make_beat(REQ_DIM, 1'b1, 4'h0, 4'h0, 4'h0, 4'h0));
    pending_beats.push_back(make_beat(REQ_DIM, 1'b0, 4'h0, 4'h0, 4'h0, 4'h0));
    repeat (3) pending_beats.push_back(random_beat(REQ_TICK));
    pending_beats.push_back(make_beat(REQ_LOAD, 1'b1, 4'h0, 4'hF, 4'h5, 4'hA));
    pending_beats.push_back(make_beat(REQ_LOAD, 1'b0, 4'hF, 4'hF, 4'hF, 4'hF));
    repeat (2) pending_beats.push_back(random_beat(REQ_TICK));
    wait_idle();

    run_phase(40, 8, 2, 30, 150, 1'b1);
    run_phase(1, 255, 1, 1, 100, 1'b1);
    run_phase(30, 10, 10, 50, 100, 1'b0);
    run_phase(100, 20, 19, 7, 100, 1'b1);

    // Longest frame and fade, with bright below dim so no single steps occur.
    set_config(65535, 2, 254, 1048575);
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    pending_beats.push_back(make_beat(REQ_LOAD, 1'b0, 4'h3, 4'hC, 4'h6, 4'h9));
    repeat (60) pending_beats.push_back(random_beat(REQ_TICK));
    wait_idle();

    repeat (4) begin
      bright = $urandom_range(2, 40);
      dim = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 254) : $urandom_range(1, bright - 1);
      run_phase($urandom_range(1, 5 * bright + 8), bright, dim, $urandom_range(1, 120), 90, 1'b1);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
